// ===== design/lsf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Learning switch forwarder package
// Shared widths, parameter defaults, reset values and register indexes.
// ----------------------------------------------------------------------------
package lsf_pkg;

  // Parameter defaults
  localparam int unsigned PORTS_DEF       = 8;
  localparam int unsigned QUEUE_DEPTH_DEF = 64;
  localparam int unsigned ADDR_BITS_DEF   = 16;

  // Field widths
  localparam int unsigned PORT_W     = 3;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned TAG_W      = 32;
  localparam int unsigned MASK_W     = 8;
  localparam int unsigned NPORTS_W   = 4;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_PORTS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BCAST_LIMIT = 1'd1;

  // Register reset values
  localparam logic [NPORTS_W-1:0] NUM_PORTS_RST   = 4'd8;
  localparam logic [ADDR_W-1:0]   BCAST_LIMIT_RST = 16'd1000;

endpackage : lsf_pkg
`default_nettype wire

// ===== design/lsf_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Learning switch forwarder channels
// Valid/ready channels for arriving switch cycles and forwarding results.
// ----------------------------------------------------------------------------
interface lsf_in_if
  import lsf_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              has_packet;
  logic [PORT_W-1:0] in_port;
  logic [ADDR_W-1:0] src_addr;
  logic [ADDR_W-1:0] dst_addr;
  logic [TAG_W-1:0]  payload_tag;

  modport source (output valid, has_packet, in_port, src_addr, dst_addr, payload_tag,
                  input ready);
  modport sink   (input valid, has_packet, in_port, src_addr, dst_addr, payload_tag,
                  output ready);
endinterface : lsf_in_if

interface lsf_out_if
  import lsf_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              sent;
  logic [MASK_W-1:0] port_mask;
  logic [ADDR_W-1:0] out_src_addr;
  logic [ADDR_W-1:0] out_dst_addr;
  logic [TAG_W-1:0]  out_payload_tag;
  logic              overwrote;

  modport source (output valid, sent, port_mask, out_src_addr, out_dst_addr,
                         out_payload_tag, overwrote,
                  input ready);
  modport sink   (input valid, sent, port_mask, out_src_addr, out_dst_addr,
                        out_payload_tag, overwrote,
                  output ready);
endinterface : lsf_out_if
`default_nettype wire

// ===== design/learning_switch_forwarder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Output: the result of a transaction is captured in the output
//   register at the edge that accepts it and is offered in the following cycle.
// Throughput: one transaction per cycle; input stalls only while a result waits
//   in the output register and the result channel is not ready.
// Reset: learned table cleared, queue empty, registers at their defaults; the
//   queue memory needs no clearing pass.
// ----------------------------------------------------------------------------
// Learning switch forwarder
// Learns source addresses per port, queues packet descriptors in a ring and
// forwards the queue head to the learned port or as a broadcast.
// ----------------------------------------------------------------------------
module learning_switch_forwarder
  import lsf_pkg::*;
#(
  parameter int unsigned PORTS       = PORTS_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned ADDR_BITS   = ADDR_BITS_DEF
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  lsf_in_if.sink                in_i,
  lsf_out_if.source             out_o,
  input  wire                   cfg_we_i,
  input  wire [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(PORTS + 1);
  localparam int unsigned CW = (ADDR_BITS > ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int unsigned MW = (PORTS > MASK_W) ? PORTS : MASK_W;

  typedef struct packed {
    logic [ADDR_BITS-1:0] src;
    logic [ADDR_BITS-1:0] dst;
    logic [TAG_W-1:0]     tag;
    logic [PORT_W-1:0]    port;
  } entry_t;

  function automatic logic [QW-1:0] ring_nxt(input logic [QW-1:0] idx);
    ring_nxt = (idx == QW'(QUEUE_DEPTH - 1)) ? '0 : idx + QW'(1);
  endfunction

  // Configuration and control state
  logic [NPORTS_W-1:0]  num_ports_q;
  logic [ADDR_W-1:0]    bcast_limit_q;
  logic [ADDR_BITS-1:0] learned_addr_q [PORTS];
  logic [PORTS-1:0]     learned_valid_q;
  logic [QW-1:0]        head_q, tail_q;
  logic                 out_valid_q;

  // Queue memory and prefetch of head and head+1
  entry_t               queue_mem_q [QUEUE_DEPTH];
  entry_t               rd0_q, rd1_q, wbuf_q;
  logic                 hit0_q, hit1_q;

  // Output payload
  logic                 sent_q;
  logic [MASK_W-1:0]    port_mask_q;
  logic [ADDR_W-1:0]    out_src_q, out_dst_q;
  logic [TAG_W-1:0]     out_tag_q;
  logic                 overwrote_q;

  logic                 accept;
  logic [NW-1:0]        n_use;
  logic                 wr;
  entry_t               new_ent;
  logic [QW-1:0]        tail_nx, head_a, tail_a, head_d, head_d1, tail_d;
  logic                 full_drop, send, was_empty;
  entry_t               head0, head1, snd_ent;
  logic [ADDR_BITS-1:0] la_eff [PORTS];
  logic [PORTS-1:0]     lv_eff;
  logic                 above_limit, found;
  logic [PORTS-1:0]     hit_mask, fwd_mask;
  logic [MW-1:0]        mask_wide;

  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;

  // Clamp the port count to 1..PORTS
  always_comb begin
    if (num_ports_q == '0) begin
      n_use = NW'(1);
    end else if (32'(num_ports_q) > PORTS) begin
      n_use = NW'(PORTS);
    end else begin
      n_use = NW'(num_ports_q);
    end
  end

  // Arrival: enqueue only when it comes on a port in use
  assign wr = accept && in_i.has_packet && (32'(in_i.in_port) < 32'(n_use));
  assign new_ent.src  = ADDR_BITS'(in_i.src_addr);
  assign new_ent.dst  = ADDR_BITS'(in_i.dst_addr);
  assign new_ent.tag  = in_i.payload_tag;
  assign new_ent.port = in_i.in_port;

  // Ring pointers after the write and the send
  assign was_empty = (head_q == tail_q);
  assign tail_nx   = ring_nxt(tail_q);
  assign full_drop = wr && (tail_nx == head_q);
  assign head_a    = full_drop ? ring_nxt(head_q) : head_q;
  assign tail_a    = wr ? tail_nx : tail_q;
  assign send      = accept && (head_a != tail_a);
  assign head_d    = send ? ring_nxt(head_a) : head_a;
  assign head_d1   = ring_nxt(head_d);
  assign tail_d    = tail_a;

  // Prefetched head entries, with bypass of last cycle's write
  assign head0 = hit0_q ? wbuf_q : rd0_q;
  assign head1 = hit1_q ? wbuf_q : rd1_q;

  // Pick the entry that leaves the queue
  always_comb begin
    if (was_empty) begin
      snd_ent = new_ent;
    end else if (full_drop) begin
      snd_ent = head1;
    end else begin
      snd_ent = head0;
    end
  end

  // Learned table as seen after this arrival
  always_comb begin
    for (int p = 0; p < PORTS; p++) begin
      if (wr && (32'(in_i.in_port) == p)) begin
        la_eff[p] = new_ent.src;
        lv_eff[p] = 1'b1;
      end else begin
        la_eff[p] = learned_addr_q[p];
        lv_eff[p] = learned_valid_q[p];
      end
    end
  end

  // Look up the lowest learned port, else flood all ports in use but the arrival one
  assign above_limit = CW'(snd_ent.dst) >= CW'(bcast_limit_q);

  always_comb begin
    found    = 1'b0;
    hit_mask = '0;
    fwd_mask = '0;
    for (int p = PORTS - 1; p >= 0; p--) begin
      if (above_limit && (p < 32'(n_use)) && lv_eff[p] && (la_eff[p] == snd_ent.dst)) begin
        found    = 1'b1;
        hit_mask = PORTS'(1) << p;
      end
    end
    if (found) begin
      fwd_mask = hit_mask;
    end else begin
      for (int p = 0; p < PORTS; p++) begin
        fwd_mask[p] = (p < 32'(n_use)) && (p != 32'(snd_ent.port));
      end
    end
  end

  assign mask_wide = MW'(fwd_mask);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ports_q     <= NUM_PORTS_RST;
      bcast_limit_q   <= BCAST_LIMIT_RST;
      learned_valid_q <= '0;
      for (int p = 0; p < PORTS; p++) begin
        learned_addr_q[p] <= '0;
      end
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NUM_PORTS:   num_ports_q   <= cfg_wdata_i[NPORTS_W-1:0];
          CFG_BCAST_LIMIT: bcast_limit_q <= cfg_wdata_i[ADDR_W-1:0];
          default: ;
        endcase
      end
      for (int p = 0; p < PORTS; p++) begin
        learned_addr_q[p]  <= la_eff[p];
      end
      learned_valid_q <= lv_eff;
      head_q <= head_d;
      tail_q <= tail_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Queue memory: write at tail, read new head and its successor
  always_ff @(posedge clk_i) begin
    if (wr) begin
      queue_mem_q[tail_q] <= new_ent;
    end
    rd0_q <= queue_mem_q[head_d];
    rd1_q <= queue_mem_q[head_d1];
  end

  // Hold this cycle's write for the prefetch bypass
  always_ff @(posedge clk_i) begin
    wbuf_q <= new_ent;
    hit0_q <= wr && (tail_q == head_d);
    hit1_q <= wr && (tail_q == head_d1);
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sent_q      <= send;
      overwrote_q <= full_drop;
      if (send) begin
        port_mask_q <= mask_wide[MASK_W-1:0];
        out_src_q   <= ADDR_W'(snd_ent.src);
        out_dst_q   <= ADDR_W'(snd_ent.dst);
        out_tag_q   <= snd_ent.tag;
      end else begin
        port_mask_q <= '0;
        out_src_q   <= '0;
        out_dst_q   <= '0;
        out_tag_q   <= '0;
      end
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.sent            = sent_q;
  assign out_o.port_mask       = port_mask_q;
  assign out_o.out_src_addr    = out_src_q;
  assign out_o.out_dst_addr    = out_dst_q;
  assign out_o.out_payload_tag = out_tag_q;
  assign out_o.overwrote       = overwrote_q;

endmodule : learning_switch_forwarder
`default_nettype wire

// ===== sim/learning_switch_forwarder_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Learning switch forwarder result checker
// Watches the arrival channel, the result channel and the register port.
// Keeps its own learned-address table and descriptor ring, forecasts the
// forwarding decision for each accepted switch cycle and compares every
// accepted result against the oldest forecast, field by field.
// ----------------------------------------------------------------------------
module learning_switch_forwarder_checker
  import lsf_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  lsf_in_if                    in_i,
  lsf_out_if                   out_i,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  localparam int unsigned RING_IDX_W = $clog2(QUEUE_DEPTH_DEF);

  typedef struct packed {
    logic              sent;
    logic [MASK_W-1:0] port_mask;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [TAG_W-1:0]  payload_tag;
    logic              overwrote;
  } fwd_result_t;

  // Register copies
  logic [NPORTS_W-1:0]   num_ports;
  logic [ADDR_W-1:0]     bcast_limit;

  // Learned station table, one row per port
  logic [ADDR_W-1:0]     station_addr  [PORTS_DEF];
  logic                  station_known [PORTS_DEF];

  // Descriptor ring
  logic [ADDR_W-1:0]     ring_src  [QUEUE_DEPTH_DEF];
  logic [ADDR_W-1:0]     ring_dst  [QUEUE_DEPTH_DEF];
  logic [TAG_W-1:0]      ring_tag  [QUEUE_DEPTH_DEF];
  logic [PORT_W-1:0]     ring_port [QUEUE_DEPTH_DEF];
  logic [RING_IDX_W-1:0] ring_head;
  logic [RING_IDX_W-1:0] ring_tail;

  fwd_result_t           forecast_q [$];
  fwd_result_t           want_r;
  int unsigned           fail_count;

  // Advance one switch cycle: learn, enqueue, then forward the ring head
  function automatic fwd_result_t forward_cycle(input logic              has_pkt,
                                                input logic [PORT_W-1:0] port,
                                                input logic [ADDR_W-1:0] src,
                                                input logic [ADDR_W-1:0] dst,
                                                input logic [TAG_W-1:0]  tag);
    fwd_result_t           r;
    int unsigned           active;
    logic [RING_IDX_W-1:0] h;
    logic                  hit;
    r   = '0;
    hit = 1'b0;
    if (num_ports == 0) begin
      active = 1;
    end else if (num_ports > PORTS_DEF) begin
      active = PORTS_DEF;
    end else begin
      active = num_ports;
    end

    // Learn and enqueue; a full ring drops its oldest descriptor
    if (has_pkt && port < active) begin
      station_addr[port]   = src;
      station_known[port]  = 1'b1;
      ring_src[ring_tail]  = src;
      ring_dst[ring_tail]  = dst;
      ring_tag[ring_tail]  = tag;
      ring_port[ring_tail] = port;
      ring_tail            = ring_tail + 1'b1;
      if (ring_tail == ring_head) begin
        ring_head   = ring_head + 1'b1;
        r.overwrote = 1'b1;
      end
    end

    // Forward the head: lowest learned port, else flood all but the arrival port
    if (ring_head != ring_tail) begin
      h             = ring_head;
      r.sent        = 1'b1;
      r.src_addr    = ring_src[h];
      r.dst_addr    = ring_dst[h];
      r.payload_tag = ring_tag[h];
      if (ring_dst[h] >= bcast_limit) begin
        for (int p = 0; p < active; p++) begin
          if (!hit && station_known[p] && station_addr[p] == ring_dst[h]) begin
            r.port_mask[p] = 1'b1;
            hit            = 1'b1;
          end
        end
      end
      if (!hit) begin
        for (int p = 0; p < active; p++) begin
          if (p != ring_port[h]) r.port_mask[p] = 1'b1;
        end
      end
      ring_head = h + 1'b1;
    end
    return r;
  endfunction

  function automatic void compare_field(input string             field,
                                        input logic [TAG_W-1:0]  want,
                                        input logic [TAG_W-1:0]  got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endfunction

  // Track registers, forecast accepted transactions, check accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ports   = NUM_PORTS_RST;
      bcast_limit = BCAST_LIMIT_RST;
      for (int p = 0; p < PORTS_DEF; p++) begin
        station_addr[p]  = '0;
        station_known[p] = 1'b0;
      end
      ring_head  = '0;
      ring_tail  = '0;
      fail_count = 0;
      forecast_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NUM_PORTS:   num_ports   = cfg_wdata_i[NPORTS_W-1:0];
          CFG_BCAST_LIMIT: bcast_limit = cfg_wdata_i[ADDR_W-1:0];
          default: ;
        endcase
      end

      if (in_i.valid === 1'b1 && in_i.ready === 1'b1) begin
        forecast_q.push_back(forward_cycle(in_i.has_packet, in_i.in_port, in_i.src_addr,
                                           in_i.dst_addr, in_i.payload_tag));
      end

      if (out_i.valid === 1'b1 && out_i.ready === 1'b1) begin
        if (forecast_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: expected none, actual sent=%0b mask=0x%0h",
                   $time, out_i.sent, out_i.port_mask);
        end else begin
          want_r = forecast_q.pop_front();
          compare_field("sent", want_r.sent, out_i.sent);
          compare_field("port_mask", want_r.port_mask, out_i.port_mask);
          compare_field("out_src_addr", want_r.src_addr, out_i.out_src_addr);
          compare_field("out_dst_addr", want_r.dst_addr, out_i.out_dst_addr);
          compare_field("out_payload_tag", want_r.payload_tag, out_i.out_payload_tag);
          compare_field("overwrote", want_r.overwrote, out_i.overwrote);
        end
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= forecast_q.size();
  end

endmodule : learning_switch_forwarder_checker

// ===== sim/learning_switch_forwarder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Learning switch forwarder testbench
// Drives directed switch cycles covering flooding, unicast hits, ignored
// arrivals and register extremes, then random phases over several port
// counts, broadcast limits and idle/stall patterns. The checker instance
// forecasts and compares results; this top gives the verdict.
// ----------------------------------------------------------------------------
module learning_switch_forwarder_tb;
  import lsf_pkg::*;

  logic                  clk   = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int unsigned           fail_count;
  int unsigned           pending;
  int unsigned           send_idle_pct;
  int unsigned           recv_stall_pct;
  logic [NPORTS_W-1:0]   ports_cfg;
  logic [ADDR_W-1:0]     limit_cfg;
  logic [ADDR_W-1:0]     addr_pool [16];

  logic [NPORTS_W-1:0]   phase_ports [8] = '{4'd8, 4'd1, 4'd4, 4'd15, 4'd2, 4'd8, 4'd0, 4'd6};
  logic [ADDR_W-1:0]     phase_limit [8] = '{16'd1000, 16'd0, 16'hFFFF, 16'd3000,
                                             16'd1000, 16'd0, 16'd500, 16'd0};

  lsf_in_if  in_ch ();
  lsf_out_if out_ch ();

  learning_switch_forwarder DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  learning_switch_forwarder_checker u_fwd_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Present one switch cycle, with random idle gaps, and hold until accepted
  task automatic send_item(input logic              has_pkt,
                           input logic [PORT_W-1:0] port,
                           input logic [ADDR_W-1:0] src,
                           input logic [ADDR_W-1:0] dst,
                           input logic [TAG_W-1:0]  tag);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.has_packet  <= has_pkt;
    in_ch.in_port     <= port;
    in_ch.src_addr    <= src;
    in_ch.dst_addr    <= dst;
    in_ch.payload_tag <= tag;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Stop sending and wait for every forecast result to arrive
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Write both registers on consecutive edges; upper data bits of the port count are junk
  task automatic set_config(input logic [NPORTS_W-1:0] ports, input logic [ADDR_W-1:0] limit);
    logic [CFG_DATA_W-1:0] data;
    data                 = CFG_DATA_W'($urandom);
    data[NPORTS_W-1:0]   = ports;
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_NUM_PORTS;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_idx   <= CFG_BCAST_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ports_cfg = ports;
    limit_cfg = limit;
  endtask

  // Random traffic over a small address pool so that lookups hit often
  task automatic run_random(input int unsigned want);
    int unsigned         done_cnt;
    int unsigned         active;
    logic                has_pkt;
    logic [PORT_W-1:0]   port;
    logic [ADDR_W-1:0]   src;
    logic [ADDR_W-1:0]   dst;
    if (ports_cfg == 0) begin
      active = 1;
    end else if (ports_cfg > PORTS_DEF) begin
      active = PORTS_DEF;
    end else begin
      active = ports_cfg;
    end
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    addr_pool[2] = limit_cfg;
    addr_pool[3] = limit_cfg - 1'b1;
    for (int i = 4; i < 8; i++) addr_pool[i] = limit_cfg + ADDR_W'($urandom_range(1, 15));
    for (int i = 8; i < 16; i++) addr_pool[i] = ADDR_W'($urandom);
    done_cnt = 0;
    while (done_cnt < want) begin
      has_pkt = ($urandom_range(0, 99) < 90);
      if ($urandom_range(0, 99) < 85) begin
        port = PORT_W'($urandom_range(0, active - 1));
      end else begin
        port = PORT_W'($urandom_range(0, 7));
      end
      if ($urandom_range(0, 99) < 80) begin
        src = addr_pool[$urandom_range(0, 15)];
      end else begin
        src = ADDR_W'($urandom);
      end
      if ($urandom_range(0, 99) < 75) begin
        dst = addr_pool[$urandom_range(0, 15)];
      end else begin
        dst = ADDR_W'($urandom);
      end
      send_item(has_pkt, port, src, dst, $urandom);
      done_cnt++;
    end
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.has_packet  = 1'b0;
    in_ch.in_port     = '0;
    in_ch.src_addr    = '0;
    in_ch.dst_addr    = '0;
    in_ch.payload_tag = '0;
    out_ch.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_NUM_PORTS;
    cfg_wdata         = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    ports_cfg         = NUM_PORTS_RST;
    limit_cfg         = BCAST_LIMIT_RST;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: idle cycle, flooding, unicast hits, limit boundary
    send_item(1'b0, 3'd7, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(1'b1, 3'd0, 16'h1234, 16'h0000, 32'h0000_0000);
    send_item(1'b1, 3'd7, 16'hFFFF, 16'h1234, 32'hFFFF_FFFF);
    send_item(1'b1, 3'd3, 16'h1234, 16'h1234, 32'hA5A5_A5A5);
    send_item(1'b1, 3'd5, 16'h00AA, 16'hFFFF, 32'h5A5A_5A5A);
    send_item(1'b1, 3'd2, 16'h03E8, 16'h03E7, 32'h0000_0001);
    send_item(1'b1, 3'd4, 16'h5555, 16'h03E8, 32'h0000_0002);
    send_item(1'b1, 3'd6, 16'h0001, 16'h5555, 32'h0000_0003);
    send_item(1'b1, 3'd1, 16'hAAAA, 16'hAAAA, 32'h0000_0004);
    drain_results();

    // Single port: empty flood, arrival on an unused port, stale learned entry
    set_config(4'd1, 16'd1000);
    send_item(1'b1, 3'd0, 16'h0002, 16'h0003, 32'h0000_0005);
    send_item(1'b1, 3'd3, 16'h0004, 16'h0002, 32'h0000_0006);
    send_item(1'b1, 3'd0, 16'h0005, 16'hFFFF, 32'h0000_0007);
    drain_results();

    // Zero port count acts as one; zero limit makes every address eligible
    set_config(4'd0, 16'd0);
    send_item(1'b1, 3'd1, 16'h0009, 16'h0001, 32'h0000_0008);
    send_item(1'b1, 3'd0, 16'h0001, 16'h0001, 32'h0000_0009);
    send_item(1'b0, 3'd0, 16'h0000, 16'h0000, 32'h0000_000A);
    drain_results();

    // Oversized port count clamps; top limit floods all but the top address
    set_config(4'd15, 16'hFFFF);
    send_item(1'b1, 3'd6, 16'h0006, 16'hFFFF, 32'h0000_000B);
    send_item(1'b1, 3'd6, 16'h0007, 16'hFFFE, 32'h0000_000C);
    drain_results();

    // Random phases, each idling pattern twice
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) begin
        set_config(phase_ports[ph], ADDR_W'($urandom));
      end else begin
        set_config(phase_ports[ph], phase_limit[ph]);
      end
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      run_random(215);
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("learning_switch_forwarder_tb: PASS");
    end else begin
      $display("learning_switch_forwarder_tb: FAIL");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #1_000_000;
    $display("learning_switch_forwarder_tb: FAIL");
    $finish;
  end

endmodule : learning_switch_forwarder_tb
